FILE: src/trigger_hit_coincidence_matcher_assert.svh
// Assertion macros for the coincidence matcher back end.
`ifndef TRIGGER_HIT_COINCIDENCE_MATCHER_ASSERT_SVH
`define TRIGGER_HIT_COINCIDENCE_MATCHER_ASSERT_SVH

// A property that must hold at every clock edge outside reset.
`define CHM_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// A condition that must be followed by a consequence in the next cycle.
`define CHM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: src/chm_pkg.sv
// Package of types, constants and helper functions for the coincidence matcher.
package chm_pkg;

  localparam int OPEN_WINDOWS_DEF   = 4;
  localparam int TIMESTAMP_BITS_DEF = 48;
  localparam int CMD_QUEUE_DEPTH    = 4;
  localparam int RES_QUEUE_DEPTH    = 2;

  localparam int CHUNK_BITS   = 8;
  localparam int REM_BITS     = 7;
  localparam int HIT_PRESHIFT = 3;
  localparam logic [CHUNK_BITS-1:0] TRIG_DIVISOR = 8'd125;

  localparam int ENERGY_BITS = 16;
  localparam int DIFF_BITS   = 20;
  localparam int CLASS_BITS  = 2;
  localparam int OFFSET_BITS = 17;
  localparam int RES_BITS    = DIFF_BITS + ENERGY_BITS + CLASS_BITS + 1;

  localparam int APB_DATA_BITS = 32;
  localparam int APB_ADDR_BITS = 5;

  localparam logic [CLASS_BITS-1:0] CLASS_NONE       = 2'd0;
  localparam logic [CLASS_BITS-1:0] CLASS_PROMPT     = 2'd1;
  localparam logic [CLASS_BITS-1:0] CLASS_BACKGROUND = 2'd2;

  typedef enum logic [2:0] {
    REG_TRIGGER_OFFSET = 3'd0,
    REG_HOLDOFF_TIME   = 3'd1,
    REG_WINDOW_LIMIT   = 3'd2,
    REG_PROMPT_LOW     = 3'd3,
    REG_PROMPT_HIGH    = 3'd4,
    REG_BACKGROUND_LOW = 3'd5
  } reg_idx_t;

  localparam logic [OFFSET_BITS-1:0] TRIGGER_OFFSET_RST = 17'd0;
  localparam logic [DIFF_BITS-1:0]   HOLDOFF_TIME_RST   = 20'd19500;
  localparam logic [DIFF_BITS-1:0]   WINDOW_LIMIT_RST   = 20'd40000;
  localparam logic [DIFF_BITS-1:0]   PROMPT_LOW_RST     = 20'd200;
  localparam logic [DIFF_BITS-1:0]   PROMPT_HIGH_RST    = 20'd500;
  localparam logic [DIFF_BITS-1:0]   BACKGROUND_LOW_RST = 20'd2500;

  typedef struct packed {
    logic [OFFSET_BITS-1:0] trigger_offset;
    logic [DIFF_BITS-1:0]   holdoff_time;
    logic [DIFF_BITS-1:0]   window_limit;
    logic [DIFF_BITS-1:0]   prompt_low;
    logic [DIFF_BITS-1:0]   prompt_high;
    logic [DIFF_BITS-1:0]   background_low;
  } chm_cfg_t;

  // One radix-256 digit of a long division by the trigger divisor.
  // Returns the quotient digit above the new remainder.
  function automatic logic [CHUNK_BITS+REM_BITS-1:0] div_step(
    input logic [REM_BITS-1:0]   rem_in,
    input logic [CHUNK_BITS-1:0] chunk
  );
    logic [CHUNK_BITS-1:0] r;
    logic [CHUNK_BITS-1:0] q;
    r = {1'b0, rem_in};
    q = '0;
    for (int b = CHUNK_BITS - 1; b >= 0; b--) begin
      r = {r[CHUNK_BITS-2:0], chunk[b]};
      if (r >= TRIG_DIVISOR) begin
        r    = r - TRIG_DIVISOR;
        q[b] = 1'b1;
      end
    end
    return {q, r[REM_BITS-1:0]};
  endfunction

endpackage

FILE: src/chm_fifo.sv
// Small register queue used between the front and back and on the result side.
module chm_fifo
  import chm_pkg::*;
#(
  parameter int WIDTH = RES_BITS,
  parameter int DEPTH = RES_QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] din,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] dout,
  output logic             empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slot_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic             do_wr;
  logic             do_rd;

  assign full  = (count_r == CW'(DEPTH));
  assign empty = (count_r == '0);
  assign do_wr = push && !full;
  assign do_rd = pop && !empty;
  assign dout  = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_wr) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_rd) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_wr && !do_rd) begin
      count_nxt = count_r + 1'b1;
    end else if (do_rd && !do_wr) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      slot_r[wr_ptr_r] <= din;
    end
  end

endmodule

FILE: src/chm_front.sv
// Front end: timestamp scaling pipeline and trigger holdoff qualification.
module chm_front
  import chm_pkg::*;
#(
  parameter int TIMESTAMP_BITS = TIMESTAMP_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  chm_cfg_t                  cfg,
  input  logic                      in_push,
  output logic                      in_full,
  input  logic                      in_mode,
  input  logic [TIMESTAMP_BITS-1:0] in_raw_timestamp,
  input  logic [ENERGY_BITS-1:0]    in_energy,
  output logic                      cmd_push,
  output logic [TIMESTAMP_BITS+17:0] cmd_data,
  input  logic                      cmd_full
);

  localparam int NCH = (TIMESTAMP_BITS + CHUNK_BITS - 1) / CHUNK_BITS;
  localparam int QW  = NCH * CHUNK_BITS;
  localparam int TW  = TIMESTAMP_BITS + 1;
  localparam int DW  = TW + 1;

  logic                   adv;
  logic [QW-1:0]          dvd_in;

  logic                   st_v_r      [NCH];
  logic                   st_mode_r   [NCH];
  logic [ENERGY_BITS-1:0] st_energy_r [NCH];
  logic [QW-1:0]          st_dvd_r    [NCH];
  logic [QW-1:0]          st_quo_r    [NCH];
  logic [REM_BITS-1:0]    st_rem_r    [NCH];

  logic                   c_v_r;
  logic                   c_open_r;
  logic [TW-1:0]          c_time_r;
  logic [ENERGY_BITS-1:0] c_energy_r;
  logic [TW-1:0]          c_time_nxt;
  logic [TIMESTAMP_BITS-1:0] quo_last;
  logic [TW-1:0]          off_ext;

  logic                   seen_r;
  logic [TW-1:0]          last_r;
  logic [DW-1:0]          spacing;
  logic [DW-1:0]          holdoff_ext;
  logic                   spaced;

  assign adv     = !cmd_full;
  assign in_full = cmd_full;

  always_comb begin
    dvd_in = '0;
    if (in_mode) begin
      dvd_in[TIMESTAMP_BITS-1:0] = in_raw_timestamp;
    end else begin
      dvd_in[TIMESTAMP_BITS-1:0] = in_raw_timestamp >> HIT_PRESHIFT;
    end
  end

  for (genvar k = 0; k < NCH; k++) begin : g_div
    logic                         pv;
    logic                         pm;
    logic [ENERGY_BITS-1:0]       pe;
    logic [QW-1:0]                pd;
    logic [QW-1:0]                pq;
    logic [REM_BITS-1:0]          pr;
    logic [CHUNK_BITS+REM_BITS-1:0] step;
    logic [QW-1:0]                quo_nxt;

    if (k == 0) begin : g_head
      assign pv = in_push && !cmd_full;
      assign pm = in_mode;
      assign pe = in_energy;
      assign pd = dvd_in;
      assign pq = '0;
      assign pr = '0;
    end else begin : g_body
      assign pv = st_v_r[k-1];
      assign pm = st_mode_r[k-1];
      assign pe = st_energy_r[k-1];
      assign pd = st_dvd_r[k-1];
      assign pq = st_quo_r[k-1];
      assign pr = st_rem_r[k-1];
    end

    assign step = div_step(pr, pd[QW-1-k*CHUNK_BITS -: CHUNK_BITS]);

    always_comb begin
      quo_nxt = pq;
      quo_nxt[QW-1-k*CHUNK_BITS -: CHUNK_BITS] = step[CHUNK_BITS+REM_BITS-1:REM_BITS];
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        st_v_r[k] <= 1'b0;
      end else if (adv) begin
        st_v_r[k] <= pv;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        st_mode_r[k]   <= pm;
        st_energy_r[k] <= pe;
        st_dvd_r[k]    <= pd;
        st_quo_r[k]    <= quo_nxt;
        st_rem_r[k]    <= step[REM_BITS-1:0];
      end
    end
  end

  assign quo_last = st_quo_r[NCH-1][TIMESTAMP_BITS-1:0];
  assign off_ext  = {{(TW - OFFSET_BITS){cfg.trigger_offset[OFFSET_BITS-1]}},
                     cfg.trigger_offset};

  always_comb begin
    if (st_mode_r[NCH-1]) begin
      c_time_nxt = {1'b0, quo_last} + off_ext;
    end else begin
      c_time_nxt = {quo_last, 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_v_r <= 1'b0;
    end else if (adv) begin
      c_v_r <= st_v_r[NCH-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      c_open_r   <= st_mode_r[NCH-1];
      c_time_r   <= c_time_nxt;
      c_energy_r <= st_energy_r[NCH-1];
    end
  end

  // A trigger earlier than the last accepted one gives a negative spacing and is rejected.
  assign spacing     = {c_time_r[TW-1], c_time_r} - {last_r[TW-1], last_r};
  assign holdoff_ext = {{(DW - DIFF_BITS){1'b0}}, cfg.holdoff_time};
  assign spaced      = $signed(spacing) >= $signed(holdoff_ext);

  assign cmd_push = adv && c_v_r && (!c_open_r || !seen_r || spaced);
  assign cmd_data = {c_open_r, c_time_r, c_energy_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r <= 1'b0;
      last_r <= '0;
    end else if (cmd_push && c_open_r) begin
      seen_r <= 1'b1;
      last_r <= c_time_r;
    end
  end

endmodule

FILE: src/chm_back.sv
// Back end: open window store, hit matching and result sequencing.
`include "trigger_hit_coincidence_matcher_assert.svh"
module chm_back
  import chm_pkg::*;
#(
  parameter int OPEN_WINDOWS   = OPEN_WINDOWS_DEF,
  parameter int TIMESTAMP_BITS = TIMESTAMP_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  chm_cfg_t                   cfg,
  input  logic                       cmd_empty,
  input  logic [TIMESTAMP_BITS+17:0] cmd_data,
  output logic                       cmd_pop,
  input  logic                       res_full,
  output logic                       res_push,
  output logic [RES_BITS-1:0]        res_data
);

  localparam int N  = OPEN_WINDOWS;
  localparam int TW = TIMESTAMP_BITS + 1;
  localparam int DW = TW + 1;
  localparam int IW = (N > 1) ? $clog2(N) : 1;
  localparam int CW = $clog2(N + 1);

  typedef enum logic [1:0] {
    S_READY = 2'b01,
    S_EMIT  = 2'b10
  } state_t;

  state_t                 state_r, state_nxt;
  logic [N-1:0]           win_v_r, win_v_nxt;
  logic [TW-1:0]          win_t_r   [N];
  logic [TW-1:0]          win_t_nxt [N];
  logic [N-1:0]           keep_r, keep_nxt;
  logic [N-1:0]           match_r, match_nxt;
  logic [DIFF_BITS-1:0]   dlo_r [N];
  logic [ENERGY_BITS-1:0] energy_r;
  logic                   load_hit;

  logic                   c_open;
  logic [TW-1:0]          c_time;
  logic [ENERGY_BITS-1:0] c_energy;

  logic [DW-1:0]          d_e [N];
  logic [N-1:0]           close_vec;
  logic [N-1:0]           neg_vec;
  logic [DW-1:0]          limit_ext;

  logic [TW-1:0]          ext_t [N+1];
  logic [N:0]             prev_v;
  logic [TW-1:0]          ins_t [N];
  logic [N-1:0]           ins_v;

  logic [TW-1:0]          cmp_t [N];
  logic [N-1:0]           cmp_v;
  logic [CW-1:0]          pos;

  logic [N-1:0]           pick;
  logic                   last_one;
  logic [DIFF_BITS-1:0]   sel_d;
  logic [CLASS_BITS-1:0]  sel_class;

  assign c_open   = cmd_data[TW+ENERGY_BITS];
  assign c_time   = cmd_data[TW+ENERGY_BITS-1:ENERGY_BITS];
  assign c_energy = cmd_data[ENERGY_BITS-1:0];

  assign limit_ext = {{(DW - DIFF_BITS){1'b0}}, cfg.window_limit};

  always_comb begin
    for (int i = 0; i < N; i++) begin
      d_e[i]       = {c_time[TW-1], c_time} - {win_t_r[i][TW-1], win_t_r[i]};
      close_vec[i] = $signed(d_e[i]) > $signed(limit_ext);
      neg_vec[i]   = d_e[i][DW-1];
    end
  end

  // Opening a window appends it, or drops the oldest when every slot is in use.
  always_comb begin
    for (int i = 0; i < N; i++) begin
      ext_t[i] = win_t_r[i];
    end
    ext_t[N] = c_time;
    prev_v   = {win_v_r, 1'b1};
    for (int i = 0; i < N; i++) begin
      ins_t[i] = win_t_r[i];
      ins_v[i] = win_v_r[i];
      if (win_v_r[N-1]) begin
        ins_t[i] = ext_t[i+1];
        ins_v[i] = 1'b1;
      end else if (!win_v_r[i] && prev_v[i]) begin
        ins_t[i] = c_time;
        ins_v[i] = 1'b1;
      end
    end
  end

  always_comb begin
    pos   = '0;
    cmp_v = '0;
    for (int i = 0; i < N; i++) begin
      cmp_t[i] = win_t_r[i];
    end
    for (int i = 0; i < N; i++) begin
      if (keep_r[i]) begin
        cmp_t[pos[IW-1:0]] = win_t_r[i];
        cmp_v[pos[IW-1:0]] = 1'b1;
        pos = pos + 1'b1;
      end
    end
  end

  assign pick     = match_r & (~match_r + 1'b1);
  assign last_one = ((match_r & ~pick) == '0);

  always_comb begin
    sel_d = '0;
    for (int i = 0; i < N; i++) begin
      sel_d = sel_d | (dlo_r[i] & {DIFF_BITS{pick[i]}});
    end
    if (sel_d > cfg.prompt_low && sel_d < cfg.prompt_high) begin
      sel_class = CLASS_PROMPT;
    end else if (sel_d > cfg.background_low) begin
      sel_class = CLASS_BACKGROUND;
    end else begin
      sel_class = CLASS_NONE;
    end
  end

  assign res_data = {sel_d, energy_r, sel_class, last_one};

  always_comb begin
    state_nxt = state_r;
    win_v_nxt = win_v_r;
    win_t_nxt = win_t_r;
    keep_nxt  = keep_r;
    match_nxt = match_r;
    cmd_pop   = 1'b0;
    res_push  = 1'b0;
    load_hit  = 1'b0;
    case (state_r)
      S_READY: begin
        if (!cmd_empty) begin
          cmd_pop = 1'b1;
          if (c_open) begin
            win_v_nxt = ins_v;
            win_t_nxt = ins_t;
          end else begin
            keep_nxt  = win_v_r & ~close_vec;
            match_nxt = win_v_r & ~close_vec & ~neg_vec;
            load_hit  = 1'b1;
            state_nxt = S_EMIT;
          end
        end
      end
      S_EMIT: begin
        if (match_r != '0 && !res_full) begin
          res_push  = 1'b1;
          match_nxt = match_r & ~pick;
        end
        if (match_r == '0 || (!res_full && last_one)) begin
          win_v_nxt = cmp_v;
          win_t_nxt = cmp_t;
          state_nxt = S_READY;
        end
      end
      default: begin
        state_nxt = S_READY;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_READY;
      win_v_r <= '0;
      keep_r  <= '0;
      match_r <= '0;
    end else begin
      state_r <= state_nxt;
      win_v_r <= win_v_nxt;
      keep_r  <= keep_nxt;
      match_r <= match_nxt;
    end
  end

  always_ff @(posedge clk) begin
    win_t_r <= win_t_nxt;
    if (load_hit) begin
      energy_r <= c_energy;
      for (int i = 0; i < N; i++) begin
        dlo_r[i] <= d_e[i][DIFF_BITS-1:0];
      end
    end
  end

  `CHM_ASSERT(a_valid_prefix, ((win_v_r & (win_v_r + 1'b1)) == '0), "open windows not packed oldest first")
  `CHM_ASSERT(a_match_kept, ((match_r & ~keep_r) == '0), "match on a window that closes")
  `CHM_ASSERT_NEXT(a_open_fills, (state_r == S_READY && cmd_pop && c_open), win_v_r[0], "opened window missing")
  `CHM_ASSERT_NEXT(a_emit_shrinks, res_push, ($countones(match_r) + 1 == $countones($past(match_r))), "emitted match not retired")

endmodule

FILE: src/trigger_hit_coincidence_matcher.sv
// Top level of the trigger and hit coincidence window matcher.
//
// Items enter on a queue-style port: an item is taken at a clock edge with push high and full
// low. in_mode selects a trigger (1) or a detector hit (0). Results leave on a queue-style
// port: while empty is low the oldest result is on the out_ ports, and pop takes it.
// A hit gives one result for each open window that it matches, oldest window first, and
// out_last_of_run marks the final result of that hit. Triggers give no result.
// Configuration registers sit on an APB-style port at byte addresses 0 to 20, one word each.
// The timestamp scaling pipeline handles one byte of the timestamp per stage. The front end
// takes one item per cycle while the command queue is not full. The window engine takes a
// trigger in its ready state; for a hit it moves to an emit state, sends its matches one after
// another and returns to ready, taking no new item until then.
// A command queue between front end and window engine lets short bursts pass at full rate.
// When the receiver stalls, results wait in a two-entry result queue, the engine and then
// the front end hold, and full rises; no transaction is lost or repeated.
// Reset clears all open windows, the trigger history and the queues, and loads the
// register defaults.
module trigger_hit_coincidence_matcher
  import chm_pkg::*;
#(
  parameter int OPEN_WINDOWS   = OPEN_WINDOWS_DEF,
  parameter int TIMESTAMP_BITS = TIMESTAMP_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [APB_ADDR_BITS-1:0]  paddr,
  input  logic [APB_DATA_BITS-1:0]  pwdata,
  output logic [APB_DATA_BITS-1:0]  prdata,
  output logic                      pready,
  input  logic                      push,
  output logic                      full,
  input  logic                      in_mode,
  input  logic [TIMESTAMP_BITS-1:0] in_raw_timestamp,
  input  logic [ENERGY_BITS-1:0]    in_energy,
  output logic                      empty,
  input  logic                      pop,
  output logic [DIFF_BITS-1:0]      out_time_difference,
  output logic [ENERGY_BITS-1:0]    out_hit_energy,
  output logic [CLASS_BITS-1:0]     out_window_class,
  output logic                      out_last_of_run
);

  localparam int CMD_BITS = TIMESTAMP_BITS + 18;

  chm_cfg_t             cfg_r;
  logic                 reg_wr;
  logic [2:0]           reg_idx;

  logic                 cmd_push;
  logic [CMD_BITS-1:0]  cmd_wdata;
  logic                 cmd_full;
  logic                 cmd_pop;
  logic [CMD_BITS-1:0]  cmd_rdata;
  logic                 cmd_empty;

  logic                 res_push;
  logic [RES_BITS-1:0]  res_wdata;
  logic                 res_full;
  logic [RES_BITS-1:0]  res_rdata;

  assign pready  = 1'b1;
  assign reg_wr  = psel && penable && pwrite && pready;
  assign reg_idx = paddr[APB_ADDR_BITS-1:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.trigger_offset <= TRIGGER_OFFSET_RST;
      cfg_r.holdoff_time   <= HOLDOFF_TIME_RST;
      cfg_r.window_limit   <= WINDOW_LIMIT_RST;
      cfg_r.prompt_low     <= PROMPT_LOW_RST;
      cfg_r.prompt_high    <= PROMPT_HIGH_RST;
      cfg_r.background_low <= BACKGROUND_LOW_RST;
    end else if (reg_wr) begin
      case (reg_idx)
        REG_TRIGGER_OFFSET: cfg_r.trigger_offset <= pwdata[OFFSET_BITS-1:0];
        REG_HOLDOFF_TIME:   cfg_r.holdoff_time   <= pwdata[DIFF_BITS-1:0];
        REG_WINDOW_LIMIT:   cfg_r.window_limit   <= pwdata[DIFF_BITS-1:0];
        REG_PROMPT_LOW:     cfg_r.prompt_low     <= pwdata[DIFF_BITS-1:0];
        REG_PROMPT_HIGH:    cfg_r.prompt_high    <= pwdata[DIFF_BITS-1:0];
        REG_BACKGROUND_LOW: cfg_r.background_low <= pwdata[DIFF_BITS-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_TRIGGER_OFFSET: prdata = {{(APB_DATA_BITS - OFFSET_BITS){cfg_r.trigger_offset[OFFSET_BITS-1]}},
                                    cfg_r.trigger_offset};
      REG_HOLDOFF_TIME:   prdata = {{(APB_DATA_BITS - DIFF_BITS){1'b0}}, cfg_r.holdoff_time};
      REG_WINDOW_LIMIT:   prdata = {{(APB_DATA_BITS - DIFF_BITS){1'b0}}, cfg_r.window_limit};
      REG_PROMPT_LOW:     prdata = {{(APB_DATA_BITS - DIFF_BITS){1'b0}}, cfg_r.prompt_low};
      REG_PROMPT_HIGH:    prdata = {{(APB_DATA_BITS - DIFF_BITS){1'b0}}, cfg_r.prompt_high};
      REG_BACKGROUND_LOW: prdata = {{(APB_DATA_BITS - DIFF_BITS){1'b0}}, cfg_r.background_low};
      default:            prdata = '0;
    endcase
  end

  chm_front #(
    .TIMESTAMP_BITS(TIMESTAMP_BITS)
  ) u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg              (cfg_r),
    .in_push          (push),
    .in_full          (full),
    .in_mode          (in_mode),
    .in_raw_timestamp (in_raw_timestamp),
    .in_energy        (in_energy),
    .cmd_push         (cmd_push),
    .cmd_data         (cmd_wdata),
    .cmd_full         (cmd_full)
  );

  chm_fifo #(
    .WIDTH(CMD_BITS),
    .DEPTH(CMD_QUEUE_DEPTH)
  ) u_cmd_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (cmd_push),
    .din   (cmd_wdata),
    .full  (cmd_full),
    .pop   (cmd_pop),
    .dout  (cmd_rdata),
    .empty (cmd_empty)
  );

  chm_back #(
    .OPEN_WINDOWS   (OPEN_WINDOWS),
    .TIMESTAMP_BITS (TIMESTAMP_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .cmd_empty (cmd_empty),
    .cmd_data  (cmd_rdata),
    .cmd_pop   (cmd_pop),
    .res_full  (res_full),
    .res_push  (res_push),
    .res_data  (res_wdata)
  );

  chm_fifo #(
    .WIDTH(RES_BITS),
    .DEPTH(RES_QUEUE_DEPTH)
  ) u_res_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .din   (res_wdata),
    .full  (res_full),
    .pop   (pop),
    .dout  (res_rdata),
    .empty (empty)
  );

  assign out_time_difference = res_rdata[RES_BITS-1 -: DIFF_BITS];
  assign out_hit_energy      = res_rdata[CLASS_BITS+1 +: ENERGY_BITS];
  assign out_window_class    = res_rdata[1 +: CLASS_BITS];
  assign out_last_of_run     = res_rdata[0];

endmodule

FILE: tb/chm_checker.sv
// Checker for the coincidence matcher: predicts the match results of every accepted item and compares them.
`timescale 1ns / 1ps
module chm_checker
  import chm_pkg::*;
#(
  parameter int OPEN_WINDOWS   = OPEN_WINDOWS_DEF,
  parameter int TIMESTAMP_BITS = TIMESTAMP_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic                      pready,
  input  logic [APB_ADDR_BITS-1:0]  paddr,
  input  logic [APB_DATA_BITS-1:0]  pwdata,
  input  logic                      push,
  input  logic                      full,
  input  logic                      in_mode,
  input  logic [TIMESTAMP_BITS-1:0] in_raw_timestamp,
  input  logic [ENERGY_BITS-1:0]    in_energy,
  input  logic                      pop,
  input  logic                      empty,
  input  logic [DIFF_BITS-1:0]      out_time_difference,
  input  logic [ENERGY_BITS-1:0]    out_hit_energy,
  input  logic [CLASS_BITS-1:0]     out_window_class,
  input  logic                      out_last_of_run,
  output int                        mismatches,
  output int                        outstanding
);

  typedef struct {
    logic [DIFF_BITS-1:0]   time_difference;
    logic [ENERGY_BITS-1:0] hit_energy;
    logic [CLASS_BITS-1:0]  window_class;
    logic                   last_of_run;
  } match_t;

  match_t matches_due[$];

  longint window_time[OPEN_WINDOWS];
  int     open_count;
  longint last_trigger;
  bit     trigger_seen;

  longint offset_q;
  longint holdoff_q;
  longint limit_q;
  longint prompt_lo_q;
  longint prompt_hi_q;
  longint background_lo_q;

  function automatic void reset_model();
    matches_due.delete();
    open_count      = 0;
    last_trigger    = 0;
    trigger_seen    = 1'b0;
    offset_q        = $signed(TRIGGER_OFFSET_RST);
    holdoff_q       = HOLDOFF_TIME_RST;
    limit_q         = WINDOW_LIMIT_RST;
    prompt_lo_q     = PROMPT_LOW_RST;
    prompt_hi_q     = PROMPT_HIGH_RST;
    background_lo_q = BACKGROUND_LOW_RST;
  endfunction

  function automatic void apply_register_write(input logic [APB_ADDR_BITS-1:0] addr,
                                               input logic [APB_DATA_BITS-1:0] data);
    case (reg_idx_t'(addr[APB_ADDR_BITS-1:2]))
      REG_TRIGGER_OFFSET: offset_q        = $signed(data[OFFSET_BITS-1:0]);
      REG_HOLDOFF_TIME:   holdoff_q       = data[DIFF_BITS-1:0];
      REG_WINDOW_LIMIT:   limit_q         = data[DIFF_BITS-1:0];
      REG_PROMPT_LOW:     prompt_lo_q     = data[DIFF_BITS-1:0];
      REG_PROMPT_HIGH:    prompt_hi_q     = data[DIFF_BITS-1:0];
      REG_BACKGROUND_LOW: background_lo_q = data[DIFF_BITS-1:0];
      default: ;
    endcase
  endfunction

  function automatic logic [CLASS_BITS-1:0] window_class_for(input longint diff);
    if (diff > prompt_lo_q && diff < prompt_hi_q) return CLASS_PROMPT;
    if (diff > background_lo_q) return CLASS_BACKGROUND;
    return CLASS_NONE;
  endfunction

  function automatic void predict_matches(input logic                      mode,
                                          input logic [TIMESTAMP_BITS-1:0] raw,
                                          input logic [ENERGY_BITS-1:0]    energy);
    longint unsigned raw_u;
    longint          trig_t;
    longint          hit_t;
    longint          diff;
    longint          kept_time[OPEN_WINDOWS];
    int              kept;
    int              produced;
    match_t          m;
    raw_u    = raw;
    kept     = 0;
    produced = 0;
    if (mode) begin
      trig_t = longint'(raw_u / 125) + offset_q;
      if (!trigger_seen || trig_t - last_trigger >= holdoff_q) begin
        trigger_seen = 1'b1;
        last_trigger = trig_t;
        if (open_count == OPEN_WINDOWS) begin
          for (int i = 1; i < OPEN_WINDOWS; i++) window_time[i-1] = window_time[i];
          open_count = OPEN_WINDOWS - 1;
        end
        window_time[open_count] = trig_t;
        open_count = open_count + 1;
      end
    end else begin
      hit_t = longint'((raw_u / 1000) * 2);
      for (int i = 0; i < open_count; i++) begin
        diff = hit_t - window_time[i];
        if (diff <= limit_q) begin
          kept_time[kept] = window_time[i];
          kept = kept + 1;
          if (diff >= 0) begin
            m.time_difference = diff[DIFF_BITS-1:0];
            m.hit_energy      = energy;
            m.window_class    = window_class_for(diff);
            m.last_of_run     = 1'b0;
            matches_due.push_back(m);
            produced = produced + 1;
          end
        end
      end
      for (int i = 0; i < kept; i++) window_time[i] = kept_time[i];
      open_count = kept;
      if (produced > 0) matches_due[matches_due.size()-1].last_of_run = 1'b1;
    end
  endfunction

  task automatic compare_field(input string name, input logic [31:0] expected,
                               input logic [31:0] actual);
    if (actual !== expected) begin
      $error("%s: expected %0d, actual %0d", name, expected, actual);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin : watch
    match_t due;
    if (!rst_n) begin
      reset_model();
      mismatches = 0;
    end else begin
      if (psel && penable && pwrite && pready) apply_register_write(paddr, pwdata);
      if (push && !full) predict_matches(in_mode, in_raw_timestamp, in_energy);
      if (pop && !empty) begin
        if (matches_due.size() == 0) begin
          $error("result transaction with none expected: time_difference %0d",
                 out_time_difference);
          mismatches++;
        end else begin
          due = matches_due.pop_front();
          compare_field("time_difference", due.time_difference, out_time_difference);
          compare_field("hit_energy", due.hit_energy, out_hit_energy);
          compare_field("window_class", due.window_class, out_window_class);
          compare_field("last_of_run", due.last_of_run, out_last_of_run);
        end
      end
    end
    outstanding <= matches_due.size();
  end

endmodule

FILE: tb/tb.sv
// Testbench top for the coincidence matcher: clock, reset, stimulus, idling and the verdict.
`timescale 1ns / 1ps
module tb;
  import chm_pkg::*;

  localparam int     OPEN_WINDOWS   = OPEN_WINDOWS_DEF;
  localparam int     TIMESTAMP_BITS = TIMESTAMP_BITS_DEF;
  localparam int     RANDOM_ITEMS   = 470;
  localparam int     PHASES         = 7;
  localparam int     LONG_STALL     = 200;
  localparam int     SETTLE_CYCLES  = 40;
  localparam longint TIMEOUT_NS     = 5_000_000;

  logic                      clk = 1'b0;
  logic                      rst_n = 1'b0;
  logic                      psel = 1'b0;
  logic                      penable = 1'b0;
  logic                      pwrite = 1'b0;
  logic [APB_ADDR_BITS-1:0]  paddr = '0;
  logic [APB_DATA_BITS-1:0]  pwdata = '0;
  logic [APB_DATA_BITS-1:0]  prdata;
  logic                      pready;
  logic                      push = 1'b0;
  logic                      full;
  logic                      in_mode = 1'b0;
  logic [TIMESTAMP_BITS-1:0] in_raw_timestamp = '0;
  logic [ENERGY_BITS-1:0]    in_energy = '0;
  logic                      empty;
  logic                      pop = 1'b0;
  logic [DIFF_BITS-1:0]      out_time_difference;
  logic [ENERGY_BITS-1:0]    out_hit_energy;
  logic [CLASS_BITS-1:0]     out_window_class;
  logic                      out_last_of_run;
  int                        mismatches;
  int                        outstanding;

  longint now_t = 1_000_000;
  longint recent_trig[$];
  longint cfg_offset = 0;
  longint cfg_holdoff = HOLDOFF_TIME_RST;
  longint cfg_limit = WINDOW_LIMIT_RST;
  longint cfg_prompt_lo = PROMPT_LOW_RST;
  longint cfg_prompt_hi = PROMPT_HIGH_RST;
  longint cfg_background_lo = BACKGROUND_LOW_RST;
  int     random_items = 0;
  bit     no_idle = 1'b0;
  int     stall_requests = 0;
  int     stalls_done = 0;

  trigger_hit_coincidence_matcher #(
    .OPEN_WINDOWS  (OPEN_WINDOWS),
    .TIMESTAMP_BITS(TIMESTAMP_BITS)
  ) dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .psel               (psel),
    .penable            (penable),
    .pwrite             (pwrite),
    .paddr              (paddr),
    .pwdata             (pwdata),
    .prdata             (prdata),
    .pready             (pready),
    .push               (push),
    .full               (full),
    .in_mode            (in_mode),
    .in_raw_timestamp   (in_raw_timestamp),
    .in_energy          (in_energy),
    .empty              (empty),
    .pop                (pop),
    .out_time_difference(out_time_difference),
    .out_hit_energy     (out_hit_energy),
    .out_window_class   (out_window_class),
    .out_last_of_run    (out_last_of_run)
  );

  chm_checker #(
    .OPEN_WINDOWS  (OPEN_WINDOWS),
    .TIMESTAMP_BITS(TIMESTAMP_BITS)
  ) u_checker (
    .clk                (clk),
    .rst_n              (rst_n),
    .psel               (psel),
    .penable            (penable),
    .pwrite             (pwrite),
    .pready             (pready),
    .paddr              (paddr),
    .pwdata             (pwdata),
    .push               (push),
    .full               (full),
    .in_mode            (in_mode),
    .in_raw_timestamp   (in_raw_timestamp),
    .in_energy          (in_energy),
    .pop                (pop),
    .empty              (empty),
    .out_time_difference(out_time_difference),
    .out_hit_energy     (out_hit_energy),
    .out_window_class   (out_window_class),
    .out_last_of_run    (out_last_of_run),
    .mismatches         (mismatches),
    .outstanding        (outstanding)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("FAILURE");
    $finish;
  end

  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [ENERGY_BITS-1:0] pick_energy();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      default: return ENERGY_BITS'($urandom);
    endcase
  endfunction

  task automatic send_item(input logic                      mode,
                           input logic [TIMESTAMP_BITS-1:0] raw,
                           input logic [ENERGY_BITS-1:0]    energy);
    int gap;
    in_mode          <= mode;
    in_raw_timestamp <= raw;
    in_energy        <= energy;
    push             <= 1'b1;
    @(posedge clk);
    while (full) @(posedge clk);
    gap = idle_len();
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_trigger_at(input longint t);
    longint span;
    logic [TIMESTAMP_BITS-1:0] raw;
    span = t - cfg_offset;
    if (span < 0) raw = TIMESTAMP_BITS'($urandom_range(0, 124));
    else raw = TIMESTAMP_BITS'(span * 125 + longint'($urandom_range(0, 124)));
    send_item(1'b1, raw, pick_energy());
  endtask

  task automatic send_hit_at(input longint h, input logic [ENERGY_BITS-1:0] energy);
    logic [TIMESTAMP_BITS-1:0] raw;
    if (h < 0) raw = TIMESTAMP_BITS'($urandom_range(0, 999));
    else raw = TIMESTAMP_BITS'((h >>> 1) * 1000 + longint'($urandom_range(0, 999)));
    send_item(1'b0, raw, energy);
  endtask

  task automatic noise_item();
    logic [63:0]     r;
    longint unsigned span;
    r = {$urandom, $urandom};
    if ($urandom_range(0, 1)) begin
      span = (now_t - cfg_offset) * 125;
      send_item(1'b1, TIMESTAMP_BITS'(r % span), pick_energy());
    end else begin
      send_item(1'b0, r[TIMESTAMP_BITS-1:0], pick_energy());
    end
  endtask

  task automatic write_reg(input reg_idx_t idx, input longint value);
    logic [APB_DATA_BITS-1:0] data;
    data = $urandom;
    if (idx == REG_TRIGGER_OFFSET) data[OFFSET_BITS-1:0] = value[OFFSET_BITS-1:0];
    else data[DIFF_BITS-1:0] = value[DIFF_BITS-1:0];
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic configure(input longint offset, input longint holdoff, input longint limit,
                           input longint prompt_lo, input longint prompt_hi,
                           input longint background_lo);
    cfg_offset        = offset;
    cfg_holdoff       = holdoff;
    cfg_limit         = limit;
    cfg_prompt_lo     = prompt_lo;
    cfg_prompt_hi     = prompt_hi;
    cfg_background_lo = background_lo;
    write_reg(REG_TRIGGER_OFFSET, offset);
    write_reg(REG_HOLDOFF_TIME, holdoff);
    write_reg(REG_WINDOW_LIMIT, limit);
    write_reg(REG_PROMPT_LOW, prompt_lo);
    write_reg(REG_PROMPT_HIGH, prompt_hi);
    write_reg(REG_BACKGROUND_LOW, background_lo);
  endtask

  task automatic apply_phase_config(input int phase);
    longint lim;
    longint plo;
    case (phase)
      0: configure(-1234, 300, 3000, 200, 500, 1000);
      1: configure(-65536, 0, 20'hFFFFF, 0, 20'hFFFFF, 0);
      2: configure(65535, 20'hFFFFF, 0, 20'hFFFFF, 0, 20'hFFFFF);
      3: configure(longint'($urandom_range(0, 2000)) - 1000, 1000, 5000, 100, 3000, 500);
      default: begin
        lim = $urandom_range(100, 20000);
        plo = $urandom_range(0, lim / 2);
        configure(longint'($urandom_range(0, 131071)) - 65536, $urandom_range(0, 4000), lim,
                  plo, $urandom_range(plo, lim), $urandom_range(0, lim));
      end
    endcase
  endtask

  task automatic settle();
    push <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic run_episode(input int max_hits);
    longint t;
    longint d;
    longint anchor;
    int     n_trig;
    int     n_hits;
    n_trig = $urandom_range(1, OPEN_WINDOWS + 1);
    n_hits = $urandom_range(1, max_hits);
    repeat (n_trig) begin
      case ($urandom_range(0, 4))
        0:       t = now_t + cfg_holdoff;
        1:       t = now_t + cfg_holdoff + $urandom_range(1, 64);
        2:       t = now_t + $urandom_range(0, cfg_holdoff);
        3:       t = now_t - longint'($urandom_range(1, 500));
        default: t = now_t + cfg_holdoff + $urandom_range(0, cfg_limit);
      endcase
      send_trigger_at(t);
      if (t >= now_t + cfg_holdoff) now_t = t;
      recent_trig.push_back(t);
      if (recent_trig.size() > OPEN_WINDOWS) void'(recent_trig.pop_front());
      random_items++;
    end
    repeat (n_hits) begin
      anchor = recent_trig[$urandom_range(0, recent_trig.size() - 1)];
      case ($urandom_range(0, 7))
        0:       d = cfg_prompt_lo + longint'($urandom_range(0, 2));
        1:       d = cfg_prompt_hi - longint'($urandom_range(0, 2));
        2:       d = cfg_background_lo + longint'($urandom_range(0, 3)) - 1;
        3:       d = cfg_limit + longint'($urandom_range(0, 3)) - 1;
        4:       d = -longint'($urandom_range(1, 64));
        5:       d = 0;
        default: d = $urandom_range(0, cfg_limit);
      endcase
      send_hit_at(anchor + d, pick_energy());
      random_items++;
    end
    if ($urandom_range(0, 3) == 0) noise_item();
  endtask

  initial begin : receiver
    int len;
    @(posedge clk);
    forever begin
      if (stall_requests != stalls_done) begin
        pop <= 1'b0;
        repeat (LONG_STALL) @(posedge clk);
        stalls_done++;
      end else begin
        len = idle_len();
        if (len == 0) begin
          pop <= 1'b1;
          @(posedge clk);
        end else begin
          pop <= 1'b0;
          repeat (len) @(posedge clk);
        end
      end
    end
  end

  initial begin : stimulus
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Default settings: boundaries of the class limits, holdoff and window store.
    send_item(1'b0, '0, 16'h0000);
    send_item(1'b1, '0, 16'hFFFF);
    send_item(1'b0, '0, 16'hFFFF);
    send_hit_at(300, pick_energy());
    send_hit_at(200, pick_energy());
    send_hit_at(500, pick_energy());
    send_hit_at(2502, pick_energy());
    send_hit_at(2500, pick_energy());
    send_trigger_at(19499);
    send_trigger_at(19500);
    send_trigger_at(100);
    send_trigger_at(39000);
    send_trigger_at(58500);
    send_trigger_at(78000);
    send_hit_at(60000, pick_energy());
    send_hit_at(79000, pick_energy());
    send_hit_at(200000, pick_energy());
    send_hit_at(200002, pick_energy());

    for (int p = 0; p < PHASES; p++) begin
      settle();
      apply_phase_config(p);
      now_t = now_t + 3 * (cfg_limit + cfg_holdoff) + 1000;
      recent_trig.delete();
      recent_trig.push_back(now_t);
      if (p == 0) begin
        stall_requests++;
        no_idle = 1'b1;
        repeat (3) run_episode(24);
      end
      while (random_items < (p + 1) * RANDOM_ITEMS / PHASES) begin
        no_idle = ($urandom_range(0, 4) == 0);
        run_episode(8);
      end
      no_idle = 1'b0;
    end

    // Timestamps at the top of the range, after all ordinary traffic.
    send_item(1'b0, '1, 16'hFFFF);
    send_item(1'b1, '1, 16'h0000);
    noise_item();
    noise_item();
    send_item(1'b0, '1, pick_energy());

    settle();
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
